// ===== src/aspc_pkg.sv =====
package aspc_pkg;
	localparam int WINDOW_DEF = 10;
	localparam int SUM_W = 23;
	localparam logic [23:0] FACTOR_MAX = 24'h7FFFFF;
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_PRESS = 1'b1;
	localparam logic [2:0] STEP_DONE = 3'd6;

	typedef struct packed {
		logic op;
		logic signed [15:0] acc_x;
		logic signed [15:0] acc_y;
		logic signed [15:0] acc_z;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] avg_x;
		logic signed [15:0] avg_y;
		logic signed [15:0] avg_z;
		logic [2:0] step;
		logic signed [15:0] cal_x;
		logic signed [15:0] cal_y;
		logic signed [15:0] cal_z;
		logic done_res;
		logic degenerate;
	} out_item_t;
endpackage

// ===== src/aspc_if.sv =====
interface aspc_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/accel_six_position_calibrator_core.sv =====
// Six-position accelerometer calibrator.
// in_ch: op, acc_x/y/z. op 0 pushes a Q4.12 sample into a per-axis moving window
// held in one RAM; op 1 is a button press that steps the capture sequencer
// (x min, x max, y min, y max, z min, z max, then restart on the next press).
// out_ch: one result per input transfer: averages, step, calibrated values,
// done_res and degenerate.
// From input transfer to out_ch.valid: a sample does the window RAM
// read/modify/write, then three averages through a shared 29-step divider;
// a capture press does the averages only; the sixth press first does up to
// three 29-step reciprocal divisions; no division while the window is empty.
// One item at a time; in_ch.ready is low while an item is in work or the
// result waits, so a new item is taken only after the last result has left.
// The result sits in an output register until out_ch.ready; the block accepts
// nothing new meanwhile.
// Reset clears sums, fill count, slot, step, extremes, zeros, factors and flag;
// the window RAM is never cleared, entries are only read once written.
module accel_six_position_calibrator_core
	import aspc_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF
) (
	input logic clk,
	input logic arst_n,
	aspc_if.sink in_ch,
	aspc_if.source out_ch
);
	localparam int AW = $clog2(3 * WINDOW);
	localparam int SW = $clog2(WINDOW);
	localparam int FW = $clog2(WINDOW + 1);

	localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_UPD = 4'd2,
		S_COEF = 4'd3, S_ZWAIT = 4'd4, S_FDIV = 4'd5, S_FWAIT = 4'd6,
		S_AVG = 4'd7, S_AWAIT = 4'd8, S_MUL = 4'd9, S_SAT = 4'd10,
		S_OUT = 4'd11;

	logic [3:0] st_q;
	logic [1:0] ax_q;
	in_item_t it_q;
	logic signed [SUM_W-1:0] sum_q [3];
	logic [FW-1:0] fill_q;
	logic [SW-1:0] slot_q;
	logic [2:0] step_q;
	logic signed [15:0] ext_q [6];
	logic signed [15:0] zero_q [3];
	logic [23:0] fac_q [3];
	logic bad_q;
	logic signed [15:0] avg_q [3];
	logic signed [16:0] diff_q;
	logic signed [41:0] prod_q;
	logic signed [15:0] cal_q [3];
	out_item_t res_q;
	logic ovalid_q;

	logic ram_we;
	logic [AW-1:0] ram_wa, ram_ra;
	logic [15:0] ram_wd, ram_rd;

	logic dv_start, dv_neg, dv_busy;
	logic [28:0] dv_num, dv_quo;
	logic [23:0] dv_den;

	aspc_ram #(.WIDTH(16), .DEPTH(3 * WINDOW)) u_win (
		.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
		.raddr(ram_ra), .rdata(ram_rd)
	);

	aspc_div #(.NW(29), .DW(24)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .neg(dv_neg),
		.num(dv_num), .den(dv_den), .busy(dv_busy), .quo(dv_quo)
	);

	logic signed [15:0] cur_acc;
	logic signed [16:0] zsum;
	logic signed [15:0] zval;
	logic signed [16:0] dval;
	logic [AW-1:0] addr;
	logic [SUM_W-1:0] asum;
	logic signed [15:0] cap;
	logic signed [25:0] q26;

	always_comb begin
		unique case (ax_q)
			2'd0: cur_acc = it_q.acc_x;
			2'd1: cur_acc = it_q.acc_y;
			default: cur_acc = it_q.acc_z;
		endcase
		addr = AW'(ax_q * WINDOW) + AW'(slot_q);
		zsum = 17'(ext_q[2 * ax_q]) + 17'(ext_q[2 * ax_q + 1]);
		zval = zsum[16:1];
		dval = 17'(ext_q[2 * ax_q + 1]) - 17'(zval);
		asum = sum_q[ax_q][SUM_W-1] ? -sum_q[ax_q] : sum_q[ax_q];
		cap = (fill_q == '0) ? 16'sd0 : avg_q[step_q[2:1]];
		q26 = prod_q[41:16];
	end

	assign ram_ra = addr;
	assign ram_wa = addr;
	assign ram_wd = cur_acc;
	assign ram_we = st_q == S_UPD;

	always_comb begin
		dv_start = 1'b0;
		dv_neg = 1'b0;
		dv_num = '0;
		dv_den = '0;
		if (st_q == S_FDIV && dval > 0) begin
			dv_start = 1'b1;
			dv_num = 29'h1000_0000;
			dv_den = 24'(dval);
		end else if (st_q == S_AVG && fill_q != '0) begin
			dv_start = 1'b1;
			dv_neg = sum_q[ax_q][SUM_W-1];
			dv_num = 29'(asum);
			dv_den = 24'(fill_q);
		end
	end

	assign in_ch.ready = st_q == S_IDLE && !ovalid_q;
	assign out_ch.valid = ovalid_q;
	assign out_ch.data = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ax_q <= '0;
			fill_q <= '0;
			slot_q <= '0;
			step_q <= '0;
			bad_q <= 1'b0;
			ovalid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				sum_q[i] <= '0;
				zero_q[i] <= '0;
				fac_q[i] <= '0;
			end
			for (int i = 0; i < 6; i++) ext_q[i] <= '0;
		end else begin
			if (ovalid_q && out_ch.ready) ovalid_q <= 1'b0;
			unique case (st_q)
				S_IDLE: if (in_ch.valid && !ovalid_q) begin
					it_q <= in_ch.data;
					ax_q <= '0;
					if (in_ch.data.op == OP_SAMPLE) begin
						st_q <= S_RD;
					end else if (step_q < STEP_DONE) begin
						ext_q[step_q] <= cap;
						step_q <= step_q + 1'b1;
						st_q <= (step_q == 3'd5) ? S_COEF : S_AVG;
						if (step_q == 3'd5) bad_q <= 1'b0;
					end else begin
						step_q <= '0;
						fill_q <= '0;
						slot_q <= '0;
						for (int i = 0; i < 3; i++) sum_q[i] <= '0;
						st_q <= S_AVG;
					end
				end
				S_RD: st_q <= S_UPD;
				S_UPD: begin
					sum_q[ax_q] <= sum_q[ax_q] + SUM_W'(cur_acc)
						- ((fill_q == FW'(WINDOW)) ? SUM_W'(signed'(ram_rd)) : '0);
					if (ax_q == 2'd2) begin
						ax_q <= '0;
						if (fill_q != FW'(WINDOW)) fill_q <= fill_q + 1'b1;
						slot_q <= (slot_q == SW'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
						st_q <= S_AVG;
					end else begin
						ax_q <= ax_q + 1'b1;
						st_q <= S_RD;
					end
				end
				S_COEF: begin
					zero_q[ax_q] <= zval;
					st_q <= S_FDIV;
				end
				S_FDIV: begin
					if (dval > 0) begin
						st_q <= S_FWAIT;
					end else begin
						fac_q[ax_q] <= FACTOR_MAX;
						bad_q <= 1'b1;
						st_q <= S_ZWAIT;
					end
				end
				S_FWAIT: if (!dv_busy) begin
					fac_q[ax_q] <= (dv_quo > 29'(FACTOR_MAX)) ? FACTOR_MAX
						: dv_quo[23:0];
					st_q <= S_ZWAIT;
				end
				S_ZWAIT: begin
					if (ax_q == 2'd2) begin
						ax_q <= '0;
						st_q <= S_AVG;
					end else begin
						ax_q <= ax_q + 1'b1;
						st_q <= S_COEF;
					end
				end
				S_AVG: begin
					if (fill_q == '0) begin
						avg_q[ax_q] <= '0;
						diff_q <= -17'(zero_q[ax_q]);
						st_q <= S_MUL;
					end else begin
						st_q <= S_AWAIT;
					end
				end
				S_AWAIT: if (!dv_busy) begin
					avg_q[ax_q] <= dv_quo[15:0];
					diff_q <= 17'(signed'(dv_quo[15:0])) - 17'(zero_q[ax_q]);
					st_q <= S_MUL;
				end
				S_MUL: begin
					prod_q <= 42'(diff_q) * 42'(signed'({1'b0, fac_q[ax_q]}));
					st_q <= S_SAT;
				end
				S_SAT: begin
					cal_q[ax_q] <= (step_q != STEP_DONE) ? 16'sd0
						: (q26 > 26'sd32767) ? 16'sd32767
						: (q26 < -26'sd32768) ? -16'sd32768 : q26[15:0];
					if (ax_q == 2'd2) begin
						ax_q <= '0;
						st_q <= S_OUT;
					end else begin
						ax_q <= ax_q + 1'b1;
						st_q <= S_AVG;
					end
				end
				S_OUT: begin
					res_q <= '{avg_x: avg_q[0], avg_y: avg_q[1], avg_z: avg_q[2],
						step: step_q, cal_x: cal_q[0], cal_y: cal_q[1], cal_z: cal_q[2],
						done_res: step_q == STEP_DONE, degenerate: bad_q};
					ovalid_q <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== src/aspc_ram.sv =====
module aspc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== src/aspc_div.sv =====
module aspc_div #(
	parameter int NW = 29,
	parameter int DW = 24
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic neg,
	input logic [NW-1:0] num,
	input logic [DW-1:0] den,
	output logic busy,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] n_q;
	logic [DW-1:0] d_q;
	logic [DW:0] r_q;
	logic [CW-1:0] cnt_q;
	logic neg_q;
	logic [DW:0] sh;
	logic [DW:0] df;
	always_comb begin
		sh = {r_q[DW-1:0], n_q[NW-1]};
		df = sh - {1'b0, d_q};
	end
	assign busy = cnt_q != '0;
	assign quo = neg_q ? -n_q : n_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
			neg_q <= neg;
		end else if (busy) begin
			if (!df[DW]) begin
				r_q <= df;
				n_q <= {n_q[NW-2:0], 1'b1};
			end else begin
				r_q <= sh;
				n_q <= {n_q[NW-2:0], 1'b0};
			end
		end
	end
endmodule

// ===== bench/tb_sb.sv =====
`timescale 1ns / 100ps
class cal_scoreboard;
	localparam int WIN = 10;
	int win_x[WIN], win_y[WIN], win_z[WIN];
	int sum[3];
	int fill, slot, step_i;
	int extreme[6];
	int zero[3];
	longint factor[3];
	bit bad;
	aspc_pkg::out_item_t pending[$];
	int errors;

	function new();
		errors = 0;
		clear_window();
		step_i = 0;
		bad = 0;
		foreach (extreme[i]) extreme[i] = 0;
		foreach (zero[i]) begin
			zero[i] = 0;
			factor[i] = 0;
		end
	endfunction

	function void clear_window();
		foreach (sum[i]) sum[i] = 0;
		fill = 0;
		slot = 0;
	endfunction

	function int avg_of(int a);
		if (fill == 0)
			return 0;
		return sum[a] / fill;
	endfunction

	function void solve_coeffs();
		int lo, hi, s, z, d;
		bad = 0;
		for (int a = 0; a < 3; a++) begin
			lo = extreme[2 * a];
			hi = extreme[2 * a + 1];
			s = lo + hi;
			z = s >>> 1;
			d = hi - z;
			zero[a] = z;
			if (d <= 0) begin
				factor[a] = 64'h7FFFFF;
				bad = 1;
			end else begin
				factor[a] = (64'sd1 <<< 28) / d;
				if (factor[a] > 64'h7FFFFF)
					factor[a] = 64'h7FFFFF;
			end
		end
	endfunction

	function logic signed [15:0] scaled(int a, int avg);
		longint p, q;
		p = longint'(avg - zero[a]) * factor[a];
		q = p >>> 16;
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return q[15:0];
	endfunction

	function void note_transfer(aspc_pkg::in_item_t it);
		aspc_pkg::out_item_t r;
		int v[3];
		int av[3];
		bit fin;
		if (it.op == aspc_pkg::OP_SAMPLE) begin
			v[0] = it.acc_x;
			v[1] = it.acc_y;
			v[2] = it.acc_z;
			if (fill >= WIN) begin
				sum[0] -= win_x[slot];
				sum[1] -= win_y[slot];
				sum[2] -= win_z[slot];
			end
			win_x[slot] = v[0];
			win_y[slot] = v[1];
			win_z[slot] = v[2];
			foreach (v[i]) sum[i] += v[i];
			if (fill < WIN) fill++;
			slot = (slot + 1 >= WIN) ? 0 : slot + 1;
		end else if (step_i < 6) begin
			extreme[step_i] = avg_of(step_i >> 1);
			step_i++;
			if (step_i == 6) solve_coeffs();
		end else begin
			clear_window();
			step_i = 0;
		end
		foreach (av[i]) av[i] = avg_of(i);
		fin = step_i >= 6;
		r.avg_x = 16'(av[0]);
		r.avg_y = 16'(av[1]);
		r.avg_z = 16'(av[2]);
		r.step = step_i[2:0];
		r.cal_x = fin ? scaled(0, av[0]) : 16'sd0;
		r.cal_y = fin ? scaled(1, av[1]) : 16'sd0;
		r.cal_z = fin ? scaled(2, av[2]) : 16'sd0;
		r.done_res = fin;
		r.degenerate = bad;
		pending.push_back(r);
	endfunction

	function void check_result(aspc_pkg::out_item_t got);
		aspc_pkg::out_item_t e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result %h", $time, got);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (e.avg_x !== got.avg_x || e.avg_y !== got.avg_y || e.avg_z !== got.avg_z ||
				e.step !== got.step || e.cal_x !== got.cal_x || e.cal_y !== got.cal_y ||
				e.cal_z !== got.cal_z || e.done_res !== got.done_res ||
				e.degenerate !== got.degenerate) begin
			$display("%0t: mismatch expected avg %0d %0d %0d step %0d cal %0d %0d %0d d %b g %b",
				$time, e.avg_x, e.avg_y, e.avg_z, e.step, e.cal_x, e.cal_y, e.cal_z,
				e.done_res, e.degenerate);
			$display("%0t:          actual   avg %0d %0d %0d step %0d cal %0d %0d %0d d %b g %b",
				$time, got.avg_x, got.avg_y, got.avg_z, got.step, got.cal_x, got.cal_y,
				got.cal_z, got.done_res, got.degenerate);
			errors++;
		end
	endfunction
endclass

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
module tb;
	import aspc_pkg::*;

	logic clk;
	logic arst_n;
	aspc_if #(in_item_t) in_ch();
	aspc_if #(out_item_t) out_ch();
	cal_scoreboard board;
	bit calm;

	accel_six_position_calibrator_core dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("tb: done, errors");
		$finish;
	end

	always @(posedge clk) begin
		if (in_ch.valid && in_ch.ready)
			board.note_transfer(in_ch.data);
		if (out_ch.valid && out_ch.ready)
			board.check_result(out_ch.data);
	end

	always @(posedge clk) begin
		out_ch.ready <= calm || ($urandom_range(99) >= 13);
	end

	task automatic send(logic op, logic [15:0] x, logic [15:0] y, logic [15:0] z);
		in_item_t it;
		while (!calm && $urandom_range(99) < 13) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		it.op = op;
		it.acc_x = x;
		it.acc_y = y;
		it.acc_z = z;
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic rand_sample(int center);
		send(OP_SAMPLE, 16'(center + int'($urandom_range(800)) - 400),
			16'(center + int'($urandom_range(800)) - 400),
			16'(center + int'($urandom_range(800)) - 400));
	endtask

	task automatic press();
		send(OP_PRESS, 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	initial begin
		int n, k, cnt;
		board = new();
		calm = 0;
		arst_n = 0;
		in_ch.valid = 0;
		in_ch.data = '0;
		out_ch.ready = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// empty window captures, then degenerate coefficients
		for (int i = 0; i < 7; i++)
			press();
		send(OP_SAMPLE, 16'h7FFF, 16'h8000, 16'h0000);
		send(OP_SAMPLE, 16'h8000, 16'h7FFF, 16'hFFFF);
		send(OP_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send(OP_SAMPLE, 16'h8000, 16'h8000, 16'h8000);
		for (int i = 0; i < 12; i++)
			send(OP_SAMPLE, 16'h8000, 16'h8000, 16'h8000);
		press();
		press();
		cnt = 0;
		while (cnt < 1080) begin
			calm = (cnt > 300 && cnt < 420);
			k = $urandom_range(99);
			if (k < 75) begin
				// well-formed six-position run
				for (int p = 0; p < 6; p++) begin
					n = $urandom_range(1, 14);
					for (int s = 0; s < n; s++) begin
						if ($urandom_range(9) == 0)
							send(OP_SAMPLE, 16'($urandom), 16'($urandom), 16'($urandom));
						else
							rand_sample((p % 2) ? 4096 : -4096);
					end
					cnt += n;
					press();
					cnt++;
				end
				for (int s = 0; s < 4; s++)
					rand_sample(int'($urandom_range(8192)) - 4096);
				press();
				cnt += 5;
			end else begin
				n = $urandom_range(1, 8);
				for (int s = 0; s < n; s++) begin
					if ($urandom_range(2) == 0)
						press();
					else
						send(OP_SAMPLE, 16'($urandom), 16'($urandom), 16'($urandom));
				end
				cnt += n;
			end
		end
		in_ch.valid <= 1'b0;
		calm = 0;
		n = 0;
		while (board.pending.size() != 0 && n < 100000) begin
			@(posedge clk);
			n++;
		end
		repeat (200) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule

// ===== files.f =====
src/aspc_pkg.sv
src/aspc_if.sv
src/aspc_ram.sv
src/aspc_div.sv
src/accel_six_position_calibrator_core.sv
bench/tb_sb.sv
bench/tb.sv
